// ----- hdl/manhdr_pkg.sv -----
// Shared types and constants for the manual-page header field splitter.
// Used by the step logic, the top level and the port checker.
`timescale 1ns / 1ps

package manhdr_pkg;

    typedef enum logic [1:0] {
        PH_SEARCH,
        PH_LINE,
        PH_DONE
    } phase_t;

    localparam logic [1:0] KIND_BYTE = 2'd0;
    localparam logic [1:0] KIND_END  = 2'd1;
    localparam logic [1:0] KIND_CAT  = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [2:0] TOK_SECTION  = 3'd1;
    localparam logic [2:0] TOK_LAST     = 3'd4;
    localparam logic [2:0] SECT_MAX_LEN = 3'd4;
    localparam logic [2:0] LEN_SAT      = 3'd5;
    localparam logic [2:0] MATCH_FULL   = 3'd4;

    typedef struct packed {
        phase_t     phase;
        logic       at_line_start;
        logic [2:0] match_count;
        logic [2:0] token_index;
        logic       quote_odd;
        logic [2:0] token_length;
        logic       first_was_quote;
        logic       prev_was_quote;
        logic [3:0] section_digit;
    } pstate_t;

    localparam pstate_t PSTATE_RESET = '{
        phase:           PH_SEARCH,
        at_line_start:   1'b1,
        match_count:     3'd0,
        token_index:     3'd0,
        quote_odd:       1'b0,
        token_length:    3'd0,
        first_was_quote: 1'b0,
        prev_was_quote:  1'b0,
        section_digit:   4'd0
    };

    typedef struct packed {
        logic [1:0] out_kind;
        logic [1:0] field_type;
        logic [7:0] text_byte;
        logic       commit;
        logic       strip_quotes;
        logic [3:0] section_code;
        logic       last_result;
    } result_t;

    localparam result_t RESULT_NONE = '0;

    typedef struct packed {
        logic [1:0] count;
        result_t    res0;
        result_t    res1;
        pstate_t    state_next;
    } step_t;

    function automatic logic [7:0] head_char(input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = 8'h2E;
            2'd1:    c = 8'h54;
            2'd2:    c = 8'h48;
            default: c = CH_SPACE;
        endcase
        return c;
    endfunction

endpackage

// ----- hdl/manpage_header_field_splitter.sv -----
// Top level of the manual-page header field splitter: parser state and result queue.
// Depends on manhdr_pkg and manhdr_step.
`timescale 1ns / 1ps

// The block takes one document byte per clock cycle while s_ready is high and finds the
// first line that starts with ".TH ". The bytes of the title, date, source and book-title
// tokens come out as keyword words, each token closed by an end-of-keyword word, and
// the section token becomes a category word. A byte causes zero, one or two result words;
// the parser state is updated in the cycle the byte is accepted and the words go into a
// four-entry result queue that drives the m_ ports, where the words of a byte are offered
// behind any words still waiting in the queue. s_ready is high while the queue has room
// for two words, so input runs at one byte per cycle as long as the results are taken at
// least as fast as they are produced; a byte that causes two words drains in two transfers.
module manpage_header_field_splitter
    import manhdr_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_last_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_out_kind,
    output logic [1:0] m_field_type,
    output logic [7:0] m_text_byte,
    output logic       m_commit,
    output logic       m_strip_quotes,
    output logic [3:0] m_section_code,
    output logic       m_last_result
);

    pstate_t    state_reg;
    step_t      step;
    result_t    queue_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       accept;
    logic       pop;
    logic [1:0] push_n;
    result_t    head;

    manhdr_step u_step (
        .state     (state_reg),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .step      (step)
    );

    assign s_ready = (count_reg <= 3'd2);
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != 3'd0);
    assign pop     = m_valid && m_ready;
    assign push_n  = accept ? step.count : 2'd0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + push_n;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_n} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= PSTATE_RESET;
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end else begin
            if (accept) begin
                state_reg <= step.state_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_n != 2'd0) begin
            queue_reg[wr_ptr_reg] <= step.res0;
        end
        if (push_n == 2'd2) begin
            queue_reg[wr_ptr_reg + 2'd1] <= step.res1;
        end
    end

    assign head           = queue_reg[rd_ptr_reg];
    assign m_out_kind     = head.out_kind;
    assign m_field_type   = head.field_type;
    assign m_text_byte    = head.text_byte;
    assign m_commit       = head.commit;
    assign m_strip_quotes = head.strip_quotes;
    assign m_section_code = head.section_code;
    assign m_last_result  = head.last_result;

endmodule

// ----- hdl/manhdr_step.sv -----
// Per-byte parser step: next parser state and up to two result words.
// Depends on manhdr_pkg.
`timescale 1ns / 1ps

module manhdr_step
    import manhdr_pkg::*;
(
    input  pstate_t    state,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output step_t      step
);

    typedef struct packed {
        pstate_t state;
        logic    emit;
        result_t res;
    } fin_t;

    function automatic logic [1:0] text_type(input logic [2:0] tidx);
        logic [2:0] t;
        t = tidx - 3'd1;
        return (tidx == 3'd0) ? 2'd0 : t[1:0];
    endfunction

    function automatic pstate_t clear_token(input pstate_t s);
        pstate_t c;
        c = s;
        c.quote_odd       = 1'b0;
        c.token_length    = 3'd0;
        c.first_was_quote = 1'b0;
        c.prev_was_quote  = 1'b0;
        c.section_digit   = 4'd0;
        return c;
    endfunction

    function automatic fin_t finish_token(input pstate_t s, input logic at_eol);
        fin_t f;
        f.state = s;
        f.emit  = 1'b0;
        f.res   = RESULT_NONE;
        if (s.token_index == TOK_SECTION) begin
            if (!s.quote_odd && s.token_length != 3'd0 && s.token_length <= SECT_MAX_LEN
                && s.section_digit != 4'd0) begin
                f.emit             = 1'b1;
                f.res.out_kind     = KIND_CAT;
                f.res.section_code = s.section_digit;
            end
        end else if (s.token_length != 3'd0) begin
            f.emit             = 1'b1;
            f.res.out_kind     = KIND_END;
            f.res.field_type   = text_type(s.token_index);
            f.res.commit       = !s.quote_odd;
            f.res.strip_quotes = !s.quote_odd && s.first_was_quote && s.prev_was_quote
                                 && s.token_length >= 3'd2;
        end
        f.state = clear_token(s);
        if (at_eol || s.token_index >= TOK_LAST) begin
            f.state.phase = PH_DONE;
        end else begin
            f.state.token_index = s.token_index + 3'd1;
        end
        return f;
    endfunction

    pstate_t s1;
    fin_t    fin_line;
    fin_t    fin_last;
    logic    e1;
    result_t r1;
    logic    is_first;
    logic    is_quote;

    always_comb begin
        s1       = state;
        e1       = 1'b0;
        r1       = RESULT_NONE;
        is_quote = (data_byte == CH_QUOTE);
        is_first = (state.token_length == 3'd0) && !state.first_was_quote;
        fin_line = finish_token(state, data_byte == CH_LF);

        unique case (state.phase)
            PH_SEARCH: begin
                if (state.match_count == 3'd0) begin
                    if (state.at_line_start && data_byte == head_char(2'd0)) begin
                        s1.match_count = 3'd1;
                    end
                end else if (state.match_count < MATCH_FULL
                             && data_byte == head_char(state.match_count[1:0])) begin
                    s1.match_count = state.match_count + 3'd1;
                    if (s1.match_count == MATCH_FULL) begin
                        s1             = clear_token(s1);
                        s1.phase       = PH_LINE;
                        s1.match_count = 3'd0;
                        s1.token_index = 3'd0;
                    end
                end else begin
                    s1.match_count = 3'd0;
                end
                s1.at_line_start = (data_byte == CH_LF);
            end
            PH_LINE: begin
                if (data_byte == CH_LF || (data_byte == CH_SPACE && !state.quote_odd)) begin
                    s1 = fin_line.state;
                    e1 = fin_line.emit;
                    r1 = fin_line.res;
                end else begin
                    s1.quote_odd      = state.quote_odd ^ is_quote;
                    s1.prev_was_quote = is_quote;
                    if (state.token_index == TOK_SECTION) begin
                        if (is_first && is_quote) begin
                            s1.first_was_quote = 1'b1;
                        end else begin
                            if (state.token_length == 3'd0) begin
                                s1.section_digit = (data_byte >= CH_ONE && data_byte <= CH_NINE)
                                                   ? data_byte[3:0] : 4'd0;
                            end
                            if (state.token_length < LEN_SAT) begin
                                s1.token_length = state.token_length + 3'd1;
                            end
                        end
                    end else begin
                        if (is_first) begin
                            s1.first_was_quote = is_quote;
                        end
                        e1              = 1'b1;
                        r1.out_kind     = KIND_BYTE;
                        r1.field_type   = text_type(state.token_index);
                        r1.text_byte    = data_byte;
                        if (state.token_length < LEN_SAT) begin
                            s1.token_length = state.token_length + 3'd1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        fin_last = finish_token(s1, 1'b1);

        step.state_next = s1;
        step.res0       = RESULT_NONE;
        step.res1       = RESULT_NONE;
        step.count      = 2'd0;
        if (last_byte) begin
            step.state_next = PSTATE_RESET;
        end
        if (last_byte && s1.phase == PH_LINE && fin_last.emit) begin
            if (e1) begin
                step.res0             = r1;
                step.res1             = fin_last.res;
                step.res1.last_result = 1'b1;
                step.count            = 2'd2;
            end else begin
                step.res0             = fin_last.res;
                step.res0.last_result = 1'b1;
                step.count            = 2'd1;
            end
        end else if (e1) begin
            step.res0             = r1;
            step.res0.last_result = 1'b1;
            step.count            = 2'd1;
        end
    end

endmodule

// ----- hdl/manhdr_checker.sv -----
// Port-level checker for the manual-page header field splitter, with its bind.
// Depends on manhdr_pkg; attaches to manpage_header_field_splitter.
`timescale 1ns / 1ps

module manhdr_checker
    import manhdr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [1:0] m_out_kind,
    input logic [1:0] m_field_type,
    input logic [7:0] m_text_byte,
    input logic       m_commit,
    input logic       m_strip_quotes,
    input logic [3:0] m_section_code
);

    // A stalled result word must stay offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result word dropped while stalled");

    // Category words carry a section 1 to 9 and no keyword fields.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == KIND_CAT |->
            m_section_code >= 4'd1 && m_section_code <= 4'd9
            && m_field_type == 2'd0 && !m_commit && !m_strip_quotes && m_text_byte == 8'd0)
        else $error("malformed category word");

    // Keyword byte words carry no end-of-keyword flags and no section.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_kind == KIND_BYTE |->
            !m_commit && !m_strip_quotes && m_section_code == 4'd0)
        else $error("malformed keyword byte word");

    // Quote stripping applies only to a kept keyword end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_strip_quotes |-> m_commit && m_out_kind == KIND_END)
        else $error("strip flag on a word that is not a kept keyword end");

    // The kind code above the category code is never produced.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_out_kind == KIND_BYTE || m_out_kind == KIND_END
                    || m_out_kind == KIND_CAT)
        else $error("unknown result kind");

endmodule

bind manpage_header_field_splitter manhdr_checker u_manhdr_checker (.*);

// ----- tb/manpage_header_field_splitter_test.sv -----
// Self-checking testbench for manpage_header_field_splitter: directed and random documents
// against an in-bench prediction of the header parser, with random idling and back-pressure.
// Depends on manhdr_pkg and the RTL of the block.
`timescale 1ns / 1ps

module manpage_header_field_splitter_test;
    import manhdr_pkg::*;

    localparam int          ITEM_TARGET     = 400;
    localparam int          FULL_RATE_ITEMS = 60;
    localparam int          HOLD_OFF_CYCLES = 120;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          CYCLE_LIMIT     = 200000;
    localparam int          MAX_REPORTS     = 10;
    localparam logic [31:0] HEADER_TAG      = {8'h2E, 8'h54, 8'h48, 8'h20};
    localparam logic [1:0]  FIELD_TITLE     = 2'd0;
    localparam logic [7:0]  DIGIT_ZERO      = 8'h30;
    localparam logic [7:0]  LETTER_A        = 8'h61;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_data_byte    = 8'd0;
    logic       s_last_byte    = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [1:0] m_out_kind;
    logic [1:0] m_field_type;
    logic [7:0] m_text_byte;
    logic       m_commit;
    logic       m_strip_quotes;
    logic [3:0] m_section_code;
    logic       m_last_result;

    manpage_header_field_splitter DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_kind     (m_out_kind),
        .m_field_type   (m_field_type),
        .m_text_byte    (m_text_byte),
        .m_commit       (m_commit),
        .m_strip_quotes (m_strip_quotes),
        .m_section_code (m_section_code),
        .m_last_result  (m_last_result)
    );

    always #5 aclk = ~aclk;

    // Parser state as predicted from the bytes accepted so far.
    phase_t     parse_phase;
    logic       line_start;
    logic [2:0] tag_matched;
    logic [2:0] field_index;
    logic       quotes_open;
    logic [2:0] field_len;
    logic       opened_with_quote;
    logic       ended_with_quote;
    logic [3:0] section_num;

    result_t    step_words[$];
    result_t    expected_words[$];
    logic [7:0] doc_bytes[$];

    result_t    got_word;
    result_t    want_word;
    int         fail_count    = 0;
    int         bytes_sent    = 0;
    int         cycle_count   = 0;
    int         hold_cycles   = 0;
    bit         sender_gaps   = 1'b1;
    bit         receiver_gaps = 1'b1;
    bit         hold_off_req  = 1'b0;

    task clear_field();
        quotes_open       = 1'b0;
        field_len         = 3'd0;
        opened_with_quote = 1'b0;
        ended_with_quote  = 1'b0;
        section_num       = 4'd0;
    endtask

    task reset_parser();
        parse_phase = PH_SEARCH;
        line_start  = 1'b1;
        tag_matched = 3'd0;
        field_index = 3'd0;
        clear_field();
    endtask

    function logic [1:0] text_field_type();
        logic [2:0] t;
        t = field_index - 3'd1;
        return (field_index == 3'd0) ? FIELD_TITLE : t[1:0];
    endfunction

    task push_word(input logic [1:0] kind, input logic [1:0] ftype, input logic [7:0] text,
                   input logic keep, input logic strip, input logic [3:0] code);
        step_words.push_back({kind, ftype, text, keep, strip, code, 1'b0});
    endtask

    task close_field(input bit at_eol);
        if (field_index == TOK_SECTION) begin
            if (!quotes_open && field_len >= 3'd1 && field_len <= SECT_MAX_LEN &&
                section_num != 4'd0)
                push_word(KIND_CAT, FIELD_TITLE, 8'd0, 1'b0, 1'b0, section_num);
        end else if (field_len > 3'd0) begin
            push_word(KIND_END, text_field_type(), 8'd0, !quotes_open,
                      !quotes_open && opened_with_quote && ended_with_quote &&
                      field_len >= 3'd2, 4'd0);
        end
        clear_field();
        if (at_eol || field_index >= TOK_LAST)
            parse_phase = PH_DONE;
        else
            field_index = field_index + 3'd1;
    endtask

    task header_line_byte(input logic [7:0] b);
        logic       first_of_field;
        logic [7:0] digit;
        if (b == CH_LF) begin
            close_field(1'b1);
            return;
        end
        if (b == CH_SPACE && !quotes_open) begin
            close_field(1'b0);
            return;
        end
        first_of_field = (field_len == 3'd0) && !opened_with_quote;
        if (b == CH_QUOTE)
            quotes_open = ~quotes_open;
        ended_with_quote = (b == CH_QUOTE);
        if (field_index == TOK_SECTION) begin
            if (first_of_field && b == CH_QUOTE) begin
                opened_with_quote = 1'b1;
                return;
            end
            if (field_len == 3'd0) begin
                digit = b - CH_ONE + 8'd1;
                section_num = (b >= CH_ONE && b <= CH_NINE) ? digit[3:0] : 4'd0;
            end
        end else begin
            if (first_of_field)
                opened_with_quote = (b == CH_QUOTE);
            push_word(KIND_BYTE, text_field_type(), b, 1'b0, 1'b0, 4'd0);
        end
        if (field_len < LEN_SAT)
            field_len = field_len + 3'd1;
    endtask

    task search_byte(input logic [7:0] b);
        if (tag_matched == 3'd0) begin
            if (line_start && b == HEADER_TAG[31 -: 8])
                tag_matched = 3'd1;
        end else if (tag_matched < MATCH_FULL && b == HEADER_TAG[31 - 8 * tag_matched -: 8]) begin
            tag_matched = tag_matched + 3'd1;
            if (tag_matched == MATCH_FULL) begin
                parse_phase = PH_LINE;
                tag_matched = 3'd0;
                field_index = 3'd0;
                clear_field();
            end
        end else begin
            tag_matched = 3'd0;
        end
        line_start = (b == CH_LF);
    endtask

    task parse_byte(input logic [7:0] b, input logic last);
        step_words.delete();
        if (parse_phase == PH_SEARCH)
            search_byte(b);
        else if (parse_phase == PH_LINE)
            header_line_byte(b);
        if (last) begin
            if (parse_phase == PH_LINE)
                close_field(1'b1);
            reset_parser();
        end
        if (step_words.size() > 0)
            step_words[step_words.size() - 1].last_result = 1'b1;
        foreach (step_words[i])
            expected_words.push_back(step_words[i]);
    endtask

    task send_byte(input logic [7:0] b, input logic last);
        if (sender_gaps && $urandom_range(99) < 27) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < 27)
                @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        s_last_byte <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        parse_byte(b, last);
        bytes_sent++;
    endtask

    task send_doc();
        foreach (doc_bytes[i])
            send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
        doc_bytes.delete();
    endtask

    task append_text(input string s);
        for (int i = 0; i < s.len(); i++)
            doc_bytes.push_back(s[i]);
    endtask

    function logic [7:0] text_char();
        logic [7:0] c;
        if ($urandom_range(1) == 0) begin
            c = LETTER_A + 8'($urandom_range(25));
        end else begin
            c = 8'($urandom_range(255));
            while (c == CH_LF || c == CH_SPACE || c == CH_QUOTE)
                c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    task append_word(input int n);
        repeat (n) doc_bytes.push_back(text_char());
    endtask

    task append_section_token();
        bit quoted;
        quoted = 1'($urandom_range(1));
        if (quoted)
            doc_bytes.push_back(CH_QUOTE);
        if ($urandom_range(4) != 0)
            doc_bytes.push_back(CH_ONE + 8'($urandom_range(8)));
        else
            doc_bytes.push_back($urandom_range(1) ? DIGIT_ZERO : text_char());
        repeat ($urandom_range(0, 5))
            doc_bytes.push_back($urandom_range(3) != 0 ? DIGIT_ZERO + 8'($urandom_range(9))
                                                       : text_char());
        if ((quoted && $urandom_range(9) < 7) || (!quoted && $urandom_range(9) == 0))
            doc_bytes.push_back(CH_QUOTE);
    endtask

    task append_token();
        case ($urandom_range(9))
            4: begin
                doc_bytes.push_back(CH_QUOTE);
                append_word($urandom_range(1, 3));
                doc_bytes.push_back(CH_SPACE);
                append_word($urandom_range(1, 3));
                doc_bytes.push_back(CH_QUOTE);
            end
            5: ;
            6: append_section_token();
            7: begin
                doc_bytes.push_back(CH_QUOTE);
                append_word($urandom_range(1, 3));
            end
            8: begin
                append_word(1);
                doc_bytes.push_back(CH_QUOTE);
                append_word($urandom_range(0, 2));
                doc_bytes.push_back(CH_QUOTE);
            end
            9: begin
                doc_bytes.push_back(CH_QUOTE);
                append_word($urandom_range(0, 1));
                doc_bytes.push_back(CH_QUOTE);
            end
            default: append_word($urandom_range(1, 4));
        endcase
    endtask

    task append_filler_line();
        case ($urandom_range(5))
            0: begin
                append_text(".TH");
                append_word(2);
            end
            1: begin
                append_text(".TX ");
                append_word(2);
            end
            2: begin
                append_text(" .TH ");
                append_word(1);
            end
            3: append_text(".T");
            4: append_text(".TH z 2 y");
            default: begin
                append_word($urandom_range(1, 4));
                doc_bytes.push_back(CH_SPACE);
                append_word($urandom_range(1, 3));
            end
        endcase
        doc_bytes.push_back(CH_LF);
    endtask

    task build_header_doc();
        int fields;
        if ($urandom_range(3) == 0)
            append_filler_line();
        append_text(".TH ");
        fields = $urandom_range(0, 7);
        for (int i = 0; i < fields; i++) begin
            if (i == 1 && $urandom_range(3) != 0)
                append_section_token();
            else
                append_token();
            if (i != fields - 1 || $urandom_range(7) == 0) begin
                doc_bytes.push_back(CH_SPACE);
                if ($urandom_range(9) == 0)
                    doc_bytes.push_back(CH_SPACE);
            end
        end
        if ($urandom_range(3) != 0) begin
            doc_bytes.push_back(CH_LF);
            if ($urandom_range(1) == 0)
                append_filler_line();
            append_word($urandom_range(1, 3));
        end
    endtask

    task build_noise_doc();
        if ($urandom_range(2) == 0)
            append_text(".TH ");
        repeat ($urandom_range(1, 12)) begin
            case ($urandom_range(3))
                0: doc_bytes.push_back(8'($urandom_range(255)));
                1: doc_bytes.push_back($urandom_range(1) ? CH_SPACE : CH_QUOTE);
                2: doc_bytes.push_back($urandom_range(1) ? CH_LF : HEADER_TAG[31 -: 8]);
                default: doc_bytes.push_back(text_char());
            endcase
        end
    endtask

    task send_random_doc();
        if ($urandom_range(4) == 0)
            build_noise_doc();
        else
            build_header_doc();
        send_doc();
    endtask

    task test_directed_header();
        append_text(".TH \"t\" 9 ");
        doc_bytes.push_back(8'hFF);
        append_text("  s b");
        send_doc();
    endtask

    task test_open_quote_at_end();
        doc_bytes.push_back(CH_LF);
        append_text(".TH ");
        doc_bytes.push_back(8'h00);
        append_text(" 0 \"z");
        send_doc();
    endtask

    task test_header_on_final_byte();
        append_text(".TH ");
        send_doc();
    endtask

    task test_full_rate();
        int start;
        start         = bytes_sent;
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        while (bytes_sent < start + FULL_RATE_ITEMS)
            send_random_doc();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    task test_receiver_hold_off();
        sender_gaps  = 1'b0;
        hold_off_req = 1'b1;
        while (hold_off_req)
            send_random_doc();
        sender_gaps  = 1'b1;
    endtask

    task test_random_documents();
        while (bytes_sent < ITEM_TARGET)
            send_random_doc();
    endtask

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_OFF_CYCLES) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
                hold_off_req = 1'b0;
            end else if (receiver_gaps) begin
                m_ready <= ($urandom_range(99) >= 27);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_word = {m_out_kind, m_field_type, m_text_byte, m_commit, m_strip_quotes,
                        m_section_code, m_last_result};
            if (expected_words.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected word: kind %0d type %0d byte %h ",
                             got_word.out_kind, got_word.field_type, got_word.text_byte,
                             "commit %0d strip %0d code %0d last %0d",
                             got_word.commit, got_word.strip_quotes, got_word.section_code,
                             got_word.last_result);
            end else begin
                want_word = expected_words.pop_front();
                if (got_word.out_kind !== want_word.out_kind ||
                    got_word.field_type !== want_word.field_type ||
                    got_word.text_byte !== want_word.text_byte ||
                    got_word.commit !== want_word.commit ||
                    got_word.strip_quotes !== want_word.strip_quotes ||
                    got_word.section_code !== want_word.section_code ||
                    got_word.last_result !== want_word.last_result) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("word differs: expected kind %0d type %0d byte %h ",
                                 want_word.out_kind, want_word.field_type,
                                 want_word.text_byte,
                                 "commit %0d strip %0d code %0d last %0d, ",
                                 want_word.commit, want_word.strip_quotes,
                                 want_word.section_code, want_word.last_result,
                                 "got kind %0d type %0d byte %h ",
                                 got_word.out_kind, got_word.field_type, got_word.text_byte,
                                 "commit %0d strip %0d code %0d last %0d",
                                 got_word.commit, got_word.strip_quotes,
                                 got_word.section_code, got_word.last_result);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("manpage_header_field_splitter: mismatch");
            $finish;
        end
    end

    initial begin
        reset_parser();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_header();
        test_open_quote_at_end();
        test_header_on_final_byte();
        test_full_rate();
        test_receiver_hold_off();
        test_random_documents();
        s_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("manpage_header_field_splitter: match");
        else
            $display("manpage_header_field_splitter: mismatch");
        $finish;
    end

endmodule
